// ===== rtl/core/cbm_pkg.sv =====
// Shared types and helpers for the codebook background model.
`default_nettype none
package cbm_pkg;

    localparam int NUM_PIXELS_DEF  = 307200;
    localparam int MAX_ENTRIES_DEF = 8;
    localparam int TIME_BITS_DEF   = 16;
    localparam int PIX_MAX         = 255;
    localparam int NUM_CH          = 3;

    typedef enum logic [1:0] {
        FN_LEARN  = 2'd0,
        FN_DETECT = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NOP    = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        REG_LB0 = 3'd0,
        REG_LB1 = 3'd1,
        REG_LB2 = 3'd2,
        REG_UP  = 3'd3,
        REG_DN  = 3'd4
    } t_reg;

    localparam logic [7:0] REG_RESET = 8'd10;

    typedef struct packed {
        logic [NUM_CH-1:0][7:0] bound;
        logic [7:0]             up;
        logic [7:0]             dn;
    } t_cfg;

    typedef struct packed {
        logic [NUM_CH-1:0][7:0] lb_lo;
        logic [NUM_CH-1:0][7:0] lb_hi;
        logic [NUM_CH-1:0][7:0] sb_min;
        logic [NUM_CH-1:0][7:0] sb_max;
    } t_box;

    typedef struct packed {
        logic sel;
        logic fit;
        logic keep;
    } t_eu_flags;

    localparam int BOX_W = $bits(t_box);

endpackage
`default_nettype wire

// ===== rtl/core/codebook_background_model_top.sv =====
// Top level: codebook background model with per-pixel and per-entry memories.
// Input items arrive on s_axis: tuser carries the operation (learn, detect,
// clear, no-op); tdata carries the pixel index, three channel values and the
// advance-time flag. Every item yields one result item on m_axis (entry
// index, background flag, cleared count, table-full flag). Learn bounds and
// detect margins are written over the APB port; the user must write them only
// while the block is idle, which the block does not enforce. pready is always high.
// An accepted item reads its pixel's entry count and elapsed time, then walks
// the stored entries of that pixel (at most MAX_ENTRIES) with a read step and
// a shared entry-unit step with writeback for each entry, then writes the pixel
// back. A learn adds an append step, a no-op skips the entry walk and an
// out-of-range pixel goes straight to the finish step. One item is in work at a
// time; s_axis tready rises when the result is loaded into the output register.
// Reset: the block sweeps the pixel memory, one pixel a cycle, over all
// NUM_PIXELS pixels, zeroing entry counts and elapsed times; s_axis tready stays low.
// Stall: a result waits in the output register while m_axis tready is low;
// the next item may be accepted and worked meanwhile, but its result holds
// until the previous one is taken.
`default_nettype none
module codebook_background_model_top #(
    parameter int NUM_PIXELS  = cbm_pkg::NUM_PIXELS_DEF,
    parameter int MAX_ENTRIES = cbm_pkg::MAX_ENTRIES_DEF,
    parameter int TIME_BITS   = cbm_pkg::TIME_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    output logic        o_s_tready,
    // [18:0] pixel_index, [26:19] chan0, [34:27] chan1, [42:35] chan2,
    // [43] advance_time, [47:44] zero
    input  wire  [47:0] i_s_tdata,
    // [1:0] func
    input  wire  [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  wire         i_m_tready,
    // [3:0] entry_index, [4] is_background, [8:5] cleared_count,
    // [9] table_full, [15:10] zero
    output logic [15:0] o_m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int NSLOT  = NUM_PIXELS * MAX_ENTRIES;
    localparam int PIX_W  = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int ENT_AW = (NSLOT > 1) ? $clog2(NSLOT) : 1;
    localparam int IDX_W  = $clog2(MAX_ENTRIES + 1);
    localparam int EW     = cbm_pkg::BOX_W + 2 * TIME_BITS;
    localparam int PW     = IDX_W + TIME_BITS;

    typedef enum logic [8:0] {
        S_INIT = 9'b000000001,
        S_IDLE = 9'b000000010,
        S_PRD  = 9'b000000100,
        S_PLD  = 9'b000001000,
        S_ERD  = 9'b000010000,
        S_EPR  = 9'b000100000,
        S_APP  = 9'b001000000,
        S_PWR  = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    cbm_pkg::t_cfg r_cfg;

    logic [EW-1:0] ent_mem [NSLOT];
    logic [PW-1:0] pix_mem [NUM_PIXELS];
    logic [EW-1:0] r_ent_rdata;
    logic [PW-1:0] r_pix_rdata;

    cbm_pkg::t_func               r_func;
    logic [PIX_W-1:0]             r_pix, r_init;
    logic [ENT_AW-1:0]            r_base;
    logic [cbm_pkg::NUM_CH-1:0][7:0] r_chan;
    logic                         r_adv;
    logic [IDX_W-1:0]             r_cnt, r_idx, r_k, r_clr, r_ent_idx;
    logic [TIME_BITS-1:0]         r_t;
    logic                         r_found, r_bg, r_full;
    logic                         r_out_valid;
    logic [15:0]                  r_out;

    logic                         s_acc, in_range;
    logic                         ent_we, pix_we;
    logic [ENT_AW-1:0]            ent_waddr, ent_raddr;
    logic [EW-1:0]                ent_wdata;
    logic [PIX_W-1:0]             pix_addr;
    logic [PW-1:0]                pix_wdata;
    logic [TIME_BITS-1:0]         t_next;
    logic [IDX_W-1:0]             cnt_next;

    cbm_pkg::t_eu_flags           eu_flags;
    cbm_pkg::t_box                eu_box, eu_new_box;
    logic [TIME_BITS-1:0]         eu_lu, eu_stale;

    cbm_entry_unit #(.TIME_BITS(TIME_BITS)) u_eu (
        .i_op      (r_func),
        .i_found   (r_found),
        .i_box     (cbm_pkg::t_box'(r_ent_rdata[EW-1 -: cbm_pkg::BOX_W])),
        .i_lu      (r_ent_rdata[2*TIME_BITS-1 -: TIME_BITS]),
        .i_stale   (r_ent_rdata[TIME_BITS-1:0]),
        .i_t       (r_t),
        .i_pix     (r_chan),
        .i_cfg     (r_cfg),
        .o_flags   (eu_flags),
        .o_box     (eu_box),
        .o_lu      (eu_lu),
        .o_stale   (eu_stale),
        .o_new_box (eu_new_box)
    );

    // configuration port
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bound <= {cbm_pkg::NUM_CH{cbm_pkg::REG_RESET}};
            r_cfg.up    <= cbm_pkg::REG_RESET;
            r_cfg.dn    <= cbm_pkg::REG_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (cbm_pkg::t_reg'(paddr[4:2]))
                cbm_pkg::REG_LB0: r_cfg.bound[0] <= pwdata[7:0];
                cbm_pkg::REG_LB1: r_cfg.bound[1] <= pwdata[7:0];
                cbm_pkg::REG_LB2: r_cfg.bound[2] <= pwdata[7:0];
                cbm_pkg::REG_UP:  r_cfg.up       <= pwdata[7:0];
                cbm_pkg::REG_DN:  r_cfg.dn       <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cbm_pkg::t_reg'(paddr[4:2]))
            cbm_pkg::REG_LB0: prdata = {24'd0, r_cfg.bound[0]};
            cbm_pkg::REG_LB1: prdata = {24'd0, r_cfg.bound[1]};
            cbm_pkg::REG_LB2: prdata = {24'd0, r_cfg.bound[2]};
            cbm_pkg::REG_UP:  prdata = {24'd0, r_cfg.up};
            cbm_pkg::REG_DN:  prdata = {24'd0, r_cfg.dn};
            default:          prdata = 32'd0;
        endcase
    end

    // handshake
    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc      = i_s_tvalid && o_s_tready;
    assign in_range   = {13'd0, i_s_tdata[18:0]} < 32'(NUM_PIXELS);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // memory control
    always_comb begin
        ent_raddr = r_base + ENT_AW'(r_idx);
        ent_we    = 1'b0;
        ent_waddr = r_base + ENT_AW'(r_idx);
        ent_wdata = {eu_box, eu_lu, eu_stale};
        if (r_state == S_EPR) begin
            if (r_func == cbm_pkg::FN_LEARN) begin
                ent_we = 1'b1;
            end else if (r_func == cbm_pkg::FN_CLEAR && eu_flags.keep) begin
                ent_we    = 1'b1;
                ent_waddr = r_base + ENT_AW'(r_k);
            end
        end else if (r_state == S_APP && !r_found && r_cnt < IDX_W'(MAX_ENTRIES)) begin
            ent_we    = 1'b1;
            ent_waddr = r_base + ENT_AW'(r_cnt);
            ent_wdata = {eu_new_box, r_t, {TIME_BITS{1'b0}}};
        end

        cnt_next = (r_func == cbm_pkg::FN_CLEAR) ? r_k : r_cnt;
        t_next   = (r_func == cbm_pkg::FN_CLEAR) ? '0 : r_t;
        if (r_adv && t_next != {TIME_BITS{1'b1}})
            t_next = t_next + 1'b1;

        pix_we    = (r_state == S_INIT) || (r_state == S_PWR);
        pix_addr  = (r_state == S_INIT) ? r_init : r_pix;
        pix_wdata = (r_state == S_INIT) ? '0 : {cnt_next, t_next};
    end

    always_ff @(posedge i_clk) begin
        if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
        r_ent_rdata <= ent_mem[ent_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) pix_mem[pix_addr] <= pix_wdata;
        r_pix_rdata <= pix_mem[pix_addr];
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: if (r_init == PIX_W'(NUM_PIXELS - 1)) n_state = S_IDLE;
            S_IDLE: if (s_acc) n_state = in_range ? S_PRD : S_FIN;
            S_PRD:  n_state = S_PLD;
            S_PLD:  n_state = (r_func == cbm_pkg::FN_NOP) ? S_PWR : S_ERD;
            S_ERD: begin
                if (r_idx != r_cnt) n_state = S_EPR;
                else if (r_func == cbm_pkg::FN_LEARN) n_state = S_APP;
                else n_state = S_PWR;
            end
            S_EPR:  n_state = S_ERD;
            S_APP:  n_state = S_PWR;
            S_PWR:  n_state = S_FIN;
            S_FIN:  if (!r_out_valid || i_m_tready) n_state = S_IDLE;
            default: n_state = S_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init      <= '0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_k         <= '0;
            r_cnt       <= '0;
            r_full      <= 1'b0;
            r_ent_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT) r_init <= r_init + 1'b1;
            // load a new result, or drop the one just taken
            if (r_state == S_FIN && (!r_out_valid || i_m_tready)) r_out_valid <= 1'b1;
            else if (r_out_valid && i_m_tready) r_out_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: if (s_acc) begin
                    r_func    <= cbm_pkg::t_func'(i_s_tuser);
                    r_pix     <= PIX_W'(i_s_tdata[18:0]);
                    r_chan    <= i_s_tdata[42:19];
                    r_adv     <= i_s_tdata[43];
                    r_ent_idx <= '0;
                    r_bg      <= 1'b0;
                    r_clr     <= '0;
                    r_full    <= 1'b0;
                end
                S_PRD: r_base <= ENT_AW'(r_pix) * ENT_AW'(MAX_ENTRIES);
                S_PLD: begin
                    r_cnt   <= r_pix_rdata[PW-1 -: IDX_W];
                    r_t     <= r_pix_rdata[TIME_BITS-1:0];
                    r_idx   <= '0;
                    r_k     <= '0;
                    r_found <= 1'b0;
                end
                S_EPR: begin
                    r_idx <= r_idx + 1'b1;
                    if (eu_flags.sel) begin
                        r_found   <= 1'b1;
                        r_ent_idx <= r_idx;
                    end
                    if (r_func == cbm_pkg::FN_DETECT && eu_flags.fit) r_bg <= 1'b1;
                    if (r_func == cbm_pkg::FN_CLEAR) begin
                        if (eu_flags.keep) r_k <= r_k + 1'b1;
                        else r_clr <= r_clr + 1'b1;
                    end
                end
                S_APP: if (!r_found) begin
                    if (r_cnt < IDX_W'(MAX_ENTRIES)) begin
                        r_ent_idx <= r_cnt;
                        r_cnt     <= r_cnt + 1'b1;
                    end else begin
                        r_full    <= 1'b1;
                        r_ent_idx <= IDX_W'(MAX_ENTRIES);
                    end
                end
                S_FIN: if (!r_out_valid || i_m_tready) begin
                    r_out <= {6'd0, r_full, 4'(r_clr), r_bg, 4'(r_ent_idx)};
                end
                default: ;
            endcase
        end
    end

    // checks
    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state == S_FIN))
        else $error("result raised outside finish step");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EPR) |-> (r_idx < r_cnt))
        else $error("entry walk past entry count");
    a_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EPR) |-> (r_k <= r_idx))
        else $error("compaction write pointer ahead of read pointer");
    a_full_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (r_ent_idx == IDX_W'(MAX_ENTRIES)))
        else $error("full flag without full entry index");
endmodule
`default_nettype wire

// ===== rtl/core/cbm_entry_unit.sv =====
// Shared per-entry compare and update unit: one stored codeword per use.
`default_nettype none
module cbm_entry_unit #(
    parameter int TIME_BITS = cbm_pkg::TIME_BITS_DEF
) (
    input  wire cbm_pkg::t_func                         i_op,
    input  wire                                         i_found,
    input  wire cbm_pkg::t_box                          i_box,
    input  wire [TIME_BITS-1:0]                         i_lu,
    input  wire [TIME_BITS-1:0]                         i_stale,
    input  wire [TIME_BITS-1:0]                         i_t,
    input  wire [cbm_pkg::NUM_CH-1:0][7:0]              i_pix,
    input  wire cbm_pkg::t_cfg                          i_cfg,
    output cbm_pkg::t_eu_flags                          o_flags,
    output cbm_pkg::t_box                               o_box,
    output logic [TIME_BITS-1:0]                        o_lu,
    output logic [TIME_BITS-1:0]                        o_stale,
    output cbm_pkg::t_box                               o_new_box
);
    logic [cbm_pkg::NUM_CH-1:0][7:0] hi, lo;
    logic [8:0]                      hsum;
    logic                            match, fit, sel;
    logic [TIME_BITS-1:0]            lu_new, run;

    always_comb begin
        match = 1'b1;
        fit   = 1'b1;
        for (int n = 0; n < cbm_pkg::NUM_CH; n++) begin
            hsum  = {1'b0, i_pix[n]} + {1'b0, i_cfg.bound[n]};
            hi[n] = hsum[8] ? 8'(cbm_pkg::PIX_MAX) : hsum[7:0];
            lo[n] = (i_pix[n] >= i_cfg.bound[n]) ? i_pix[n] - i_cfg.bound[n] : 8'd0;
            if (!(i_box.lb_lo[n] <= i_pix[n] && i_pix[n] <= i_box.lb_hi[n]))
                match = 1'b0;
            if (!(({1'b0, i_pix[n]} + {1'b0, i_cfg.dn}) >= {1'b0, i_box.sb_min[n]} &&
                  {1'b0, i_pix[n]} <= ({1'b0, i_box.sb_max[n]} + {1'b0, i_cfg.up})))
                fit = 1'b0;
        end
        sel = (i_op == cbm_pkg::FN_LEARN) && !i_found && match;

        o_box = i_box;
        for (int n = 0; n < cbm_pkg::NUM_CH; n++) begin
            o_new_box.lb_lo[n]  = lo[n];
            o_new_box.lb_hi[n]  = hi[n];
            o_new_box.sb_min[n] = i_pix[n];
            o_new_box.sb_max[n] = i_pix[n];
            if (sel) begin
                if (i_box.sb_max[n] < i_pix[n]) o_box.sb_max[n] = i_pix[n];
                if (i_box.sb_min[n] > i_pix[n]) o_box.sb_min[n] = i_pix[n];
                // creep the learn box one step toward the pixel bounds
                if (i_box.lb_hi[n] < hi[n]) o_box.lb_hi[n] = i_box.lb_hi[n] + 8'd1;
                if (i_box.lb_lo[n] > lo[n]) o_box.lb_lo[n] = i_box.lb_lo[n] - 8'd1;
            end
        end

        lu_new  = sel ? i_t : i_lu;
        run     = (lu_new > i_t) ? '0 : i_t - lu_new;
        o_stale = (i_op == cbm_pkg::FN_LEARN && i_stale < run) ? run : i_stale;
        o_lu    = (i_op == cbm_pkg::FN_CLEAR) ? '0 : lu_new;

        o_flags.sel  = sel;
        o_flags.fit  = fit;
        o_flags.keep = i_stale <= (i_t >> 1);
    end
endmodule
`default_nettype wire

// ===== tb/tb_codebook_background_model_chk.sv =====
// Checker for the codebook background model: predicts each result and compares.
module tb_codebook_background_model_chk (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_s_tvalid,
    input  wire         i_s_tready,
    input  wire  [47:0] i_s_tdata,
    input  wire  [1:0]  i_s_tuser,
    input  wire         i_m_tvalid,
    input  wire         i_m_tready,
    input  wire  [15:0] i_m_tdata,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [4:0]  paddr,
    input  wire  [31:0] pwdata,
    input  wire         pready,
    output int          o_fail_count,
    output int          o_pending
);
    localparam int MAX_ENT  = cbm_pkg::MAX_ENTRIES_DEF;
    localparam int TIME_MAX = (1 << cbm_pkg::TIME_BITS_DEF) - 1;

    typedef struct packed {
        logic [3:0] entry_index;
        logic       is_background;
        logic [3:0] cleared_count;
        logic       table_full;
    } t_result;

    // codebook state, per pixel and per entry (key = pixel*MAX_ENT + entry)
    int             code_cnt [int];
    int             pix_time [int];
    logic [2:0][7:0] box_lo [int];
    logic [2:0][7:0] box_hi [int];
    logic [2:0][7:0] seen_mn [int];
    logic [2:0][7:0] seen_mx [int];
    int             upd_time [int];
    int             stale [int];

    logic [7:0] bound [3];
    logic [7:0] up_margin;
    logic [7:0] dn_margin;

    t_result results_due [$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = results_due.size();

    function automatic t_result model_item(cbm_pkg::t_func fn, int pix, logic [2:0][7:0] px,
                                           logic adv);
        t_result r;
        int base, cnt, t, idx, k, run, hi [3], lo [3], p [3];
        bit found, hit;
        r = '0;
        if (pix >= cbm_pkg::NUM_PIXELS_DEF) return r;
        base = pix * MAX_ENT;
        cnt = code_cnt.exists(pix) ? code_cnt[pix] : 0;
        t   = pix_time.exists(pix) ? pix_time[pix] : 0;
        for (int n = 0; n < 3; n++) p[n] = px[n];
        if (fn == cbm_pkg::FN_LEARN) begin
            found = 0;
            idx = 0;
            for (int n = 0; n < 3; n++) begin
                hi[n] = (p[n] + int'(bound[n]) > cbm_pkg::PIX_MAX) ? cbm_pkg::PIX_MAX
                                                                     : p[n] + int'(bound[n]);
                lo[n] = (p[n] - int'(bound[n]) < 0) ? 0 : p[n] - int'(bound[n]);
            end
            for (int i = 0; i < cnt && !found; i++) begin
                hit = 1;
                for (int n = 0; n < 3; n++)
                    if (!(box_lo[base+i][n] <= p[n] && p[n] <= box_hi[base+i][n])) hit = 0;
                if (hit) begin
                    upd_time[base+i] = t;
                    for (int n = 0; n < 3; n++) begin
                        if (seen_mx[base+i][n] < p[n]) seen_mx[base+i][n] = 8'(p[n]);
                        if (seen_mn[base+i][n] > p[n]) seen_mn[base+i][n] = 8'(p[n]);
                    end
                    found = 1;
                    idx = i;
                end
            end
            if (!found) begin
                if (cnt < MAX_ENT) begin
                    for (int n = 0; n < 3; n++) begin
                        box_lo[base+cnt][n]  = 8'(lo[n]);
                        box_hi[base+cnt][n]  = 8'(hi[n]);
                        seen_mn[base+cnt][n] = 8'(p[n]);
                        seen_mx[base+cnt][n] = 8'(p[n]);
                    end
                    upd_time[base+cnt] = t;
                    stale[base+cnt] = 0;
                    idx = cnt;
                    cnt++;
                    code_cnt[pix] = cnt;
                    found = 1;
                end else begin
                    r.table_full = 1;
                    idx = MAX_ENT;
                end
            end
            r.entry_index = 4'(idx);
            for (int s = 0; s < cnt; s++) begin
                run = (upd_time[base+s] > t) ? 0 : t - upd_time[base+s];
                if (stale[base+s] < run) stale[base+s] = run;
            end
            // creep the chosen learning box one step toward the pixel bounds
            if (found)
                for (int n = 0; n < 3; n++) begin
                    if (box_hi[base+idx][n] < hi[n]) box_hi[base+idx][n]++;
                    if (box_lo[base+idx][n] > lo[n]) box_lo[base+idx][n]--;
                end
        end else if (fn == cbm_pkg::FN_DETECT) begin
            for (int i = 0; i < cnt && !r.is_background; i++) begin
                hit = 1;
                for (int n = 0; n < 3; n++)
                    if (!(int'(seen_mn[base+i][n]) - int'(dn_margin) <= p[n] &&
                          p[n] <= int'(seen_mx[base+i][n]) + int'(up_margin))) hit = 0;
                if (hit) r.is_background = 1;
            end
        end else if (fn == cbm_pkg::FN_CLEAR) begin
            k = 0;
            for (int i = 0; i < cnt; i++) begin
                if (stale[base+i] > (t >> 1)) begin
                    r.cleared_count++;
                end else begin
                    if (k != i) begin
                        box_lo[base+k]  = box_lo[base+i];
                        box_hi[base+k]  = box_hi[base+i];
                        seen_mn[base+k] = seen_mn[base+i];
                        seen_mx[base+k] = seen_mx[base+i];
                        stale[base+k]   = stale[base+i];
                    end
                    upd_time[base+k] = 0;
                    k++;
                end
            end
            code_cnt[pix] = k;
            pix_time[pix] = 0;
        end
        t = pix_time.exists(pix) ? pix_time[pix] : 0;
        if (adv && t < TIME_MAX) pix_time[pix] = t + 1;
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d", what, got, want);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_result got, want, due;
        if (!i_rst_n) begin
            bound[0] <= cbm_pkg::REG_RESET;
            bound[1] <= cbm_pkg::REG_RESET;
            bound[2] <= cbm_pkg::REG_RESET;
            up_margin <= cbm_pkg::REG_RESET;
            dn_margin <= cbm_pkg::REG_RESET;
            fails = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (cbm_pkg::t_reg'(paddr[4:2]))
                    cbm_pkg::REG_LB0: bound[0] <= pwdata[7:0];
                    cbm_pkg::REG_LB1: bound[1] <= pwdata[7:0];
                    cbm_pkg::REG_LB2: bound[2] <= pwdata[7:0];
                    cbm_pkg::REG_UP:  up_margin <= pwdata[7:0];
                    cbm_pkg::REG_DN:  dn_margin <= pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = '{i_m_tdata[3:0], i_m_tdata[4], i_m_tdata[8:5], i_m_tdata[9]};
                if (results_due.size() == 0) begin
                    report_mismatch("unexpected result item", 1, 0);
                end else begin
                    want = results_due.pop_front();
                    if (got.entry_index != want.entry_index)
                        report_mismatch("entry_index", got.entry_index, want.entry_index);
                    if (got.is_background != want.is_background)
                        report_mismatch("is_background", got.is_background, want.is_background);
                    if (got.cleared_count != want.cleared_count)
                        report_mismatch("cleared_count", got.cleared_count, want.cleared_count);
                    if (got.table_full != want.table_full)
                        report_mismatch("table_full", got.table_full, want.table_full);
                    if (i_m_tdata[15:10] != 6'd0)
                        report_mismatch("tdata pad", i_m_tdata[15:10], 0);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                due = model_item(cbm_pkg::t_func'(i_s_tuser), int'(i_s_tdata[18:0]),
                                 i_s_tdata[42:19], i_s_tdata[43]);
                results_due.insert(results_due.size(), due);
            end
        end
    end
endmodule

// ===== tb/tb_codebook_background_model_top.sv =====
// Testbench top: drives items and register writes, gives the verdict.
module tb_codebook_background_model_top;
    localparam int CYCLE_LIMIT = 2_000_000;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tready = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    wire         s_tready, m_tvalid, pready;
    wire  [15:0] m_tdata;
    wire  [31:0] prdata;
    int          fail_count, pending, cycles;
    bit          calm;
    int          pix_pool [4] = '{0, 1, 307199, 150000};
    logic [7:0]  center [4][3];

    codebook_background_model_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    tb_codebook_background_model_chk u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // result side: random stall per item, none while calm
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            hold = calm ? 0 : $urandom_range(0, 6);
            if (hold > 0) begin
                m_tready = 0;
                repeat (hold) @(negedge i_clk);
            end
            m_tready = 1;
            do @(posedge i_clk); while (!m_tvalid);
        end
    end

    task automatic write_reg(cbm_pkg::t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1;
        @(negedge i_clk);
        psel = 0; penable = 0; pwrite = 0;
    endtask

    // caller stands at a falling edge; returns at the falling edge after acceptance
    task automatic send_item(cbm_pkg::t_func fn, logic [18:0] pix, logic [7:0] c0,
                             logic [7:0] c1, logic [7:0] c2, logic adv);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid = 0;
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid = 1;
        s_tuser = fn;
        s_tdata = {4'd0, adv, c2, c1, c0, pix};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        @(negedge i_clk);
        s_tvalid = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic random_items(int count);
        int    r, slot;
        cbm_pkg::t_func fn;
        logic [18:0] pix;
        logic [7:0]  ch [3];
        for (int k = 0; k < count; k++) begin
            if (k % 60 == 0) calm = ($urandom_range(0, 3) == 0);
            slot = $urandom_range(0, 3);
            pix = 19'(pix_pool[slot]);
            r = $urandom_range(0, 99);
            fn = r < 50 ? cbm_pkg::FN_LEARN : r < 82 ? cbm_pkg::FN_DETECT :
                 r < 92 ? cbm_pkg::FN_CLEAR : cbm_pkg::FN_NOP;
            if ($urandom_range(0, 99) < 6)
                pix = 19'($urandom_range(cbm_pkg::NUM_PIXELS_DEF, 19'h7FFFF));
            for (int n = 0; n < 3; n++) begin
                // mostly stay near the pixel's center so entries get matched
                if ($urandom_range(0, 2) != 0)
                    ch[n] = 8'(center[slot][n] + $urandom_range(0, 24) - 12);
                else
                    ch[n] = 8'($urandom_range(0, 255));
            end
            if ($urandom_range(0, 40) == 0)
                center[slot][$urandom_range(0, 2)] = 8'($urandom());
            send_item(fn, pix, ch[0], ch[1], ch[2], $urandom_range(0, 9) < 7);
        end
    endtask

    initial begin
        logic [31:0] val;
        for (int s = 0; s < 4; s++)
            for (int n = 0; n < 3; n++) center[s][n] = 8'($urandom());
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // directed: extremes, every operation, full table, out of range
        send_item(cbm_pkg::FN_LEARN, 0, 0, 0, 0, 1);
        send_item(cbm_pkg::FN_LEARN, 0, 255, 255, 255, 1);
        send_item(cbm_pkg::FN_LEARN, 0, 0, 0, 0, 1);
        send_item(cbm_pkg::FN_DETECT, 0, 0, 0, 0, 0);
        send_item(cbm_pkg::FN_DETECT, 0, 128, 128, 128, 0);
        send_item(cbm_pkg::FN_DETECT, 0, 255, 255, 255, 1);
        send_item(cbm_pkg::FN_LEARN, 19'd307199, 100, 200, 50, 1);
        send_item(cbm_pkg::FN_LEARN, 19'd307200, 1, 2, 3, 1);
        send_item(cbm_pkg::FN_DETECT, 19'h7FFFF, 255, 255, 255, 1);
        send_item(cbm_pkg::FN_NOP, 0, 9, 9, 9, 1);
        send_item(cbm_pkg::FN_NOP, 19'h7FFFF, 255, 255, 255, 1);
        send_item(cbm_pkg::FN_CLEAR, 0, 0, 0, 0, 1);
        for (int i = 0; i < 9; i++)
            send_item(cbm_pkg::FN_LEARN, 1, 8'(i * 30), 8'(255 - i * 30), 8'(i * 7), 1);
        send_item(cbm_pkg::FN_CLEAR, 1, 0, 0, 0, 0);
        send_item(cbm_pkg::FN_CLEAR, 19'd307199, 0, 0, 0, 0);

        for (int ph = 0; ph < 4; ph++) begin
            drain();
            for (int r = 0; r < 5; r++) begin
                case (ph)
                    0: val = 32'h0;
                    1: val = 32'hFFFF_FFFF;
                    2: val = $urandom();
                    default: val = $urandom_range(0, 40);
                endcase
                write_reg(cbm_pkg::t_reg'(r), val);
            end
            random_items(430);
        end
        drain();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
